>>> hw/rtl/atmw_pkg.sv
// ----------------------------------------------------------------------------
// atmw_pkg: shared types and constants for the ADC trimmed-mean alarm
// Field widths, register indexes, reset values and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package atmw_pkg;

  // Port field widths.
  localparam int unsigned SAMPLE_W      = 12;
  localparam int unsigned VALUE_W       = 12;
  localparam int unsigned LIMIT_BITS    = 12;
  localparam int unsigned SKIP_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Window geometry: eight samples, the middle four averaged.
  localparam int unsigned WINDOW_LEN = 8;
  localparam int unsigned FILL_BITS  = 3;
  localparam int unsigned TRIM_LO    = 2;
  localparam int unsigned TRIM_CNT   = 4;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LIMIT  = 2'd2;

  // Register reset values.
  localparam logic [SKIP_BITS-1:0]  SKIP_RESET = 16'd100;
  localparam logic [LIMIT_BITS-1:0] HIGH_RESET = 12'd1241;
  localparam logic [LIMIT_BITS-1:0] LOW_RESET  = 12'd250;

  // Operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_MEAN
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/atmw_intf.sv
// ----------------------------------------------------------------------------
// atmw_intf: valid/ready channels of the ADC trimmed-mean alarm
// Input word, result word and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface atmw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [atmw_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface atmw_out_if;
  logic                         valid;
  logic                         ready;
  logic                         window_done;
  logic [atmw_pkg::VALUE_W-1:0] filtered_value;
  logic                         fault;

  modport source (output valid, output window_done, output filtered_value,
                  output fault, input ready);
  modport sink   (input valid, input window_done, input filtered_value,
                  input fault, output ready);
endinterface

interface atmw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [atmw_pkg::CFG_IDX_BITS-1:0]  index;
  logic [atmw_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/atmw_sort_cell.sv
// ----------------------------------------------------------------------------
// atmw_sort_cell: one slot of the insertion-sort chain
// Holds one sample. On an insert it keeps its value, takes the new sample,
// or takes the value of its left neighbor, so the chain stays ascending.
// ----------------------------------------------------------------------------
`default_nettype none

module atmw_sort_cell #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   ins_en_i,
  input  wire logic                   slot_valid_i,
  input  wire logic [SAMPLE_BITS-1:0] new_value_i,
  input  wire logic [SAMPLE_BITS-1:0] left_value_i,
  input  wire logic                   left_gt_i,
  output      logic [SAMPLE_BITS-1:0] value_o,
  output      logic                   gt_o
);

  logic [SAMPLE_BITS-1:0] value_q, value_d;

  // An empty slot counts as larger than anything, so the new word lands
  // right after the last occupied slot when it is the largest.
  assign gt_o = !slot_valid_i || (value_q > new_value_i);

  always_comb begin
    value_d = value_q;
    if (ins_en_i) begin
      if (left_gt_i) begin
        value_d = left_value_i;
      end else if (gt_o) begin
        value_d = new_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

>>> hw/rtl/atmw_trim_mean.sv
// ----------------------------------------------------------------------------
// atmw_trim_mean: trimmed mean and window comparison
// Averages the four middle slots of the sorted chain and tests the result
// against the high and low limits.
// ----------------------------------------------------------------------------
`default_nettype none

module atmw_trim_mean #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic [SAMPLE_BITS-1:0]          mid_i [atmw_pkg::TRIM_CNT],
  input  wire logic [atmw_pkg::LIMIT_BITS-1:0] high_limit_i,
  input  wire logic [atmw_pkg::LIMIT_BITS-1:0] low_limit_i,
  output      logic [SAMPLE_BITS-1:0]          mean_o,
  output      logic                            alarm_o
);

  import atmw_pkg::*;

  localparam int unsigned SUM_BITS = SAMPLE_BITS + 2;
  localparam int unsigned CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

  logic [SUM_BITS-1:0] sum;

  assign sum = SUM_BITS'(mid_i[0]) + SUM_BITS'(mid_i[1])
             + SUM_BITS'(mid_i[2]) + SUM_BITS'(mid_i[3]);

  // Truncating divide by four.
  assign mean_o = sum[SUM_BITS-1:2];

  assign alarm_o = (CMP_BITS'(mean_o) > CMP_BITS'(high_limit_i))
                || (CMP_BITS'(mean_o) < CMP_BITS'(low_limit_i));

endmodule

`default_nettype wire

>>> hw/rtl/adc_trimmed_mean_window_alarm_core.sv
// ----------------------------------------------------------------------------
// adc_trimmed_mean_window_alarm_core: decimating trimmed-mean window alarm
// Keeps one of every skip_count+1 conversions, sorts them into an
// eight-slot insertion chain, and checks the mean of the middle four
// against two limits, setting a sticky fault.
//
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+-----------------------------------------
//   in_i     | in  | valid / ready | operation, sample
//   out_o    | out | valid / ready | window_done, filtered_value, fault
//   cfg_i    | in  | valid / ready | index, data (always ready)
//
// The word that completes a window also passes through the S_MEAN state,
// which reads the four middle slots of the sort chain.
// A new input word is taken in the cycle its predecessor's result leaves the
// output register, so a stalled result holds off only the next word.
// Reset clears the counters, the fault latch and the output valid; the
// chain contents are qualified by the fill count and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_trimmed_mean_window_alarm_core #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  atmw_in_if.sink   in_i,
  atmw_out_if.source out_o,
  atmw_cfg_if.sink  cfg_i
);

  import atmw_pkg::*;

  logic [SKIP_BITS-1:0]  skip_count_q;
  logic [LIMIT_BITS-1:0] high_limit_q, low_limit_q;
  logic [SKIP_BITS-1:0]  skip_ctr_q, skip_ctr_d;
  logic [FILL_BITS-1:0]  fill_q, fill_d;
  logic                  fault_q, fault_d;
  state_e                state_q, state_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  logic                  out_done_d, out_done_q;
  logic [VALUE_W-1:0]    out_value_d, out_value_q;
  logic                  out_fault_d, out_fault_q;

  logic                   in_fire;
  logic                   is_sample;
  logic                   keep;
  logic                   win_end;
  logic [SAMPLE_BITS-1:0] new_value;

  logic [SAMPLE_BITS-1:0] cell_value [WINDOW_LEN];
  logic                   cell_gt    [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] mid        [TRIM_CNT];
  logic [SAMPLE_BITS-1:0] mean;
  logic                   alarm;

  assign cfg_i.ready = 1'b1;

  assign in_fire   = in_i.valid && in_i.ready;
  assign is_sample = (in_i.operation == OP_SAMPLE);
  assign keep      = in_fire && is_sample && (skip_ctr_q >= skip_count_q);
  assign win_end   = keep && (fill_q == FILL_BITS'(WINDOW_LEN - 1));
  assign new_value = SAMPLE_BITS'(in_i.sample);

  // ---------------------------------------------------------------------------
  // Sort chain
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] left_value;
    logic                   left_gt;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    atmw_sort_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ins_en_i     (keep),
      .slot_valid_i (FILL_BITS'(i) < fill_q),
      .new_value_i  (new_value),
      .left_value_i (left_value),
      .left_gt_i    (left_gt),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i])
    );
  end

  for (genvar k = 0; k < TRIM_CNT; k++) begin : g_mid
    assign mid[k] = cell_value[TRIM_LO + k];
  end

  atmw_trim_mean #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mean (
    .mid_i        (mid),
    .high_limit_i (high_limit_q),
    .low_limit_i  (low_limit_q),
    .mean_o       (mean),
    .alarm_o      (alarm)
  );

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (win_end) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    out_load    = 1'b0;
    out_done_d  = 1'b0;
    out_value_d = '0;
    out_fault_d = fault_q;
    case (state_q)
      S_IDLE: begin
        in_i.ready = !out_valid_q || out_o.ready;
        if (in_fire && !win_end) begin
          out_load    = 1'b1;
          out_fault_d = is_sample ? fault_q : 1'b0;
        end
      end
      S_MEAN: begin
        out_load    = 1'b1;
        out_done_d  = 1'b1;
        out_value_d = VALUE_W'(mean);
        out_fault_d = fault_q || alarm;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    skip_ctr_d = skip_ctr_q;
    fill_d     = fill_q;
    fault_d    = fault_q;
    if (in_fire && is_sample) begin
      skip_ctr_d = keep ? '0 : skip_ctr_q + 1'b1;
    end
    if (keep) begin
      fill_d = fill_q + 1'b1;
    end
    if (in_fire && !is_sample) begin
      fault_d = 1'b0;
    end else if (state_q == S_MEAN && alarm) begin
      fault_d = 1'b1;
    end
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      skip_ctr_q   <= '0;
      fill_q       <= '0;
      fault_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skip_count_q <= SKIP_RESET;
      high_limit_q <= HIGH_RESET;
      low_limit_q  <= LOW_RESET;
    end else begin
      state_q     <= state_d;
      skip_ctr_q  <= skip_ctr_d;
      fill_q      <= fill_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_SKIP_COUNT: skip_count_q <= cfg_i.data;
          CFG_HIGH_LIMIT: high_limit_q <= cfg_i.data[LIMIT_BITS-1:0];
          CFG_LOW_LIMIT:  low_limit_q  <= cfg_i.data[LIMIT_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_done_q  <= out_done_d;
      out_value_q <= out_value_d;
      out_fault_q <= out_fault_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.window_done    = out_done_q;
  assign out_o.filtered_value = out_value_q;
  assign out_o.fault          = out_fault_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The output register is always free when the mean is written into it.
  a_mean_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MEAN) |-> !out_valid_q)
    else $error("mean cycle found the output register occupied");

  // The window-completing word produces a done result, through S_MEAN and then the output register.
  a_win_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_end |=> ##1 (out_valid_q && out_done_q))
    else $error("window completion did not yield a done result");

  // Slots one through six of the chain are ascending when the middle four are read.
  a_chain_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MEAN) |-> (cell_value[1] <= cell_value[2])
                         && (cell_value[2] <= cell_value[3])
                         && (cell_value[3] <= cell_value[4])
                         && (cell_value[4] <= cell_value[5])
                         && (cell_value[5] <= cell_value[6]))
    else $error("sort chain out of order at window end");

  // A clear word reports a cleared fault and leaves the fill count alone.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_sample) |=> (out_valid_q && !out_fault_q && !fault_q
                                 && (fill_q == $past(fill_q))))
    else $error("clear word mishandled");

endmodule

`default_nettype wire
